@@ sv/aarv_pkg.sv @@
package aarv_pkg;

  // Field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned TIME_W  = 32;

  // Timing of the hold, in milliseconds
  localparam logic [TIME_W-1:0] DELAY_MS = TIME_W'(500);
  localparam logic [TIME_W-1:0] ACCEL_MS = TIME_W'(2000);

  // Divisors of the serial divider
  localparam int unsigned STEP_MS   = 100;
  localparam int unsigned ACCEL_DIV = 1000000 >> 4;

  // Quadratic term: t2 is capped, scale is max_value / STEP_MS
  localparam int unsigned T2_W    = 21;
  localparam logic [T2_W-1:0] T2_CAP = T2_W'(1048576);
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned DELTA_W = 36;

  // Serial divider: dividend width, remainder width, counter width
  localparam int unsigned DIV_W     = 52;
  localparam int unsigned DIV_REM_W = $clog2(ACCEL_DIV);
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Serial multiplier: product width, multiplier width, counter width
  localparam int unsigned MUL_W     = DIV_W;
  localparam int unsigned MUL_BW    = T2_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_BW);

  // Configuration register indexes
  localparam logic CFG_MAX_VALUE       = 1'b0;
  localparam logic CFG_DISABLE_ALLOWED = 1'b1;

  // Input codes
  localparam logic ACT_BUTTON = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [1:0] BTN_DOWN   = 2'd0;
  localparam logic [1:0] BTN_TOGGLE = 2'd1;
  localparam logic [1:0] BTN_UP     = 2'd2;
  localparam logic [1:0] BTN_IGNORE = 2'd3;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } hold_dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LIN,
    ST_SCALE,
    ST_SQ,
    ST_MSC,
    ST_QUAD,
    ST_APPLY,
    ST_FIN
  } aarv_state_t;

  typedef enum logic {
    DIV_BY_STEP,
    DIV_BY_ACCEL
  } div_sel_t;

  typedef struct packed {
    logic             start;
    div_sel_t         sel;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [MUL_W-1:0]  a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] product;
  } mul_rsp_t;

endpackage

@@ sv/aarv_if.sv @@
interface aarv_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  button_id;
  logic        is_press;
  logic [31:0] now_ms;

  modport source (output valid, action, button_id, is_press, now_ms, input ready);
  modport sink   (input valid, action, button_id, is_press, now_ms, output ready);
endinterface

interface aarv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_value;
  logic        is_enabled;
  logic        value_changed;
  logic        needs_redraw;

  modport source (output valid, current_value, is_enabled, value_changed, needs_redraw,
                  input ready);
  modport sink   (input valid, current_value, is_enabled, value_changed, needs_redraw,
                  output ready);
endinterface

@@ sv/aarv_cdiv.sv @@
// Restoring divider by a constant, one quotient bit a cycle, MSB first.
module aarv_cdiv import aarv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  div_sel_t             sel_r, sel_nxt;
  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   dvs;
  logic                 ge;

  always_comb begin
    dvs    = (sel_r == DIV_BY_ACCEL) ? (DIV_REM_W+1)'(ACCEL_DIV) : (DIV_REM_W+1)'(STEP_MS);
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    ge     = (rem_sh >= dvs);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    sel_nxt  = sel_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      sel_nxt  = req.sel;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_REM_W'(rem_sh - dvs) : rem_sh[DIV_REM_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    sel_r <= sel_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ sv/aarv_smul.sv @@
// Shift-add multiplier, one multiplier bit a cycle, MSB first.
module aarv_smul import aarv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_W-1:0]     a_r, a_nxt;
  logic [MUL_BW-1:0]    b_r, b_nxt;
  logic [MUL_W-1:0]     acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[MUL_W-2:0], 1'b0} + (b_r[MUL_BW-1] ? a_r : '0);
      b_nxt   = {b_r[MUL_BW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

@@ sv/accelerated_auto_repeat_value_setter.sv @@
// Channel  Dir  Handshake      Payload
// in_if    in   valid/ready    action, button_id[1:0], is_press, now_ms[31:0]
// out_if   out  valid/ready    current_value[15:0], is_enabled, value_changed,
//                              needs_redraw
// cfg      in   cfg_we only    cfg_index (0 max_value, 1 disable_allowed), cfg_wdata[15:0]
//
// One request is worked on at a time; the next is taken once the result sits in
// the output register, which may still wait for out_if.ready.
// Work per request: a button event or a tick that moves nothing uses no serial unit,
// a tick on the linear ramp takes one division, a tick past the acceleration mark
// when max_value/100 is zero takes two divisions, and a tick with the quadratic term
// takes three divisions and two multiplications, on the serial divider (one quotient
// bit a cycle) and the shift-add multiplier.
// Reset is synchronous: it restores the register and value state, no sweep needed.
// A stalled output holds its result; the sequencer waits in its final state.
module accelerated_auto_repeat_value_setter import aarv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  aarv_in_if.sink            in_if,
  aarv_out_if.source         out_if,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [VALUE_W-1:0] cfg_wdata
);

  aarv_state_t         state_r, state_nxt;

  // Configuration
  logic [VALUE_W-1:0]  max_value_r, max_value_nxt;
  logic                disable_allowed_r, disable_allowed_nxt;

  // Control state
  logic [VALUE_W-1:0]  held_r, held_nxt;
  logic                en_r, en_nxt;
  hold_dir_t           dir_r, dir_nxt;
  logic [VALUE_W-1:0]  start_value_r, start_value_nxt;
  logic [TIME_W-1:0]   start_time_r, start_time_nxt;

  // Captured request and working values
  logic                action_r, action_nxt;
  logic [1:0]          button_r, button_nxt;
  logic                press_r, press_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic [DELTA_W-1:0]  delta_r, delta_nxt;
  logic                changed_r, changed_nxt;
  logic                redraw_r, redraw_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_en_r, out_en_nxt;
  logic                out_changed_r, out_changed_nxt;
  logic                out_redraw_r, out_redraw_nxt;

  // Shared serial units
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  mul_req_t            mul_req;
  mul_rsp_t            mul_rsp;

  // Tick arithmetic
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   t_acc;
  logic [TIME_W-3:0]   t2_raw;
  logic [T2_W-1:0]     t2;
  logic [DELTA_W:0]    sum_up;
  logic [VALUE_W-1:0]  diff_dn;
  logic                started;

  aarv_cdiv u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  aarv_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_if.ready          = (state_r == ST_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.current_value = out_value_r;
  assign out_if.is_enabled    = out_en_r;
  assign out_if.value_changed = out_changed_r;
  assign out_if.needs_redraw  = out_redraw_r;

  always_comb begin
    elapsed = now_r - start_time_r;
    t_acc   = t_r - ACCEL_MS;
    t2_raw  = t_acc[TIME_W-1:2];
    t2      = (t2_raw > (TIME_W-2)'(T2_CAP)) ? T2_CAP : t2_raw[T2_W-1:0];
    // Full-width sum: a large delta must reach the clamp unwrapped
    sum_up  = (DELTA_W+1)'(start_value_r) + (DELTA_W+1)'(delta_r);
    diff_dn = start_value_r - delta_r[VALUE_W-1:0];
    started = 1'b0;

    state_nxt           = state_r;
    max_value_nxt       = max_value_r;
    disable_allowed_nxt = disable_allowed_r;
    held_nxt            = held_r;
    en_nxt              = en_r;
    dir_nxt             = dir_r;
    start_value_nxt     = start_value_r;
    start_time_nxt      = start_time_r;
    action_nxt          = action_r;
    button_nxt          = button_r;
    press_nxt           = press_r;
    now_nxt             = now_r;
    t_nxt               = t_r;
    scale_nxt           = scale_r;
    delta_nxt           = delta_r;
    changed_nxt         = changed_r;
    redraw_nxt          = redraw_r;
    out_valid_nxt       = out_valid_r && !out_if.ready;
    out_value_nxt       = out_value_r;
    out_en_nxt          = out_en_r;
    out_changed_nxt     = out_changed_r;
    out_redraw_nxt      = out_redraw_r;

    div_req = '{start: 1'b0, sel: DIV_BY_STEP, dividend: DIV_W'(t_r)};
    mul_req = '{start: 1'b0, a: MUL_W'(t2), b: t2};

    // Configuration writes land whenever they come
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_VALUE:       max_value_nxt       = cfg_wdata;
        CFG_DISABLE_ALLOWED: disable_allowed_nxt = cfg_wdata[0];
        default:             ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          action_nxt = in_if.action;
          button_nxt = in_if.button_id;
          press_nxt  = in_if.is_press;
          now_nxt    = in_if.now_ms;
          state_nxt  = ST_DECODE;
        end
      end

      ST_DECODE: begin
        changed_nxt = 1'b0;
        redraw_nxt  = 1'b0;
        state_nxt   = ST_FIN;
        if (action_r == ACT_TICK) begin
          // Only a live hold past the initial delay moves the value
          if (dir_r != DIR_NONE && elapsed > DELAY_MS) begin
            t_nxt            = elapsed - DELAY_MS;
            div_req.start    = 1'b1;
            div_req.sel      = DIV_BY_STEP;
            div_req.dividend = DIV_W'(elapsed - DELAY_MS);
            state_nxt        = ST_LIN;
          end
        end else if (button_r != BTN_IGNORE) begin
          if (press_r) begin
            if (!en_r) begin
              en_nxt     = 1'b1;
              redraw_nxt = 1'b1;
            end else if (button_r == BTN_TOGGLE && disable_allowed_r) begin
              // Disable; a running hold carries on
              en_nxt     = 1'b0;
              redraw_nxt = 1'b1;
            end else if (dir_r != DIR_NONE) begin
              // Any further press cancels the hold quietly
              dir_nxt = DIR_NONE;
            end else begin
              if (button_r == BTN_UP && held_r < max_value_r) begin
                dir_nxt  = DIR_UP;
                held_nxt = held_r + 1'b1;
                started  = 1'b1;
              end else if (button_r == BTN_DOWN && held_r != '0) begin
                dir_nxt  = DIR_DOWN;
                held_nxt = held_r - 1'b1;
                started  = 1'b1;
              end
              if (started) begin
                start_value_nxt = held_nxt;
                start_time_nxt  = now_r;
                changed_nxt     = 1'b1;
                redraw_nxt      = 1'b1;
              end
            end
          end else if (button_r == BTN_UP || button_r == BTN_DOWN) begin
            dir_nxt = DIR_NONE;
          end
        end
      end

      ST_LIN: begin
        if (div_rsp.done) begin
          delta_nxt = DELTA_W'(div_rsp.quotient);
          if (t_r > ACCEL_MS) begin
            div_req.start    = 1'b1;
            div_req.sel      = DIV_BY_STEP;
            div_req.dividend = DIV_W'(max_value_r);
            state_nxt        = ST_SCALE;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end

      ST_SCALE: begin
        if (div_rsp.done) begin
          scale_nxt = div_rsp.quotient[SCALE_W-1:0];
          if (div_rsp.quotient[SCALE_W-1:0] == '0) begin
            state_nxt = ST_APPLY;
          end else begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_W'(t2);
            mul_req.b     = t2;
            state_nxt     = ST_SQ;
          end
        end
      end

      ST_SQ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product;
          mul_req.b     = MUL_BW'(scale_r);
          state_nxt     = ST_MSC;
        end
      end

      ST_MSC: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.sel      = DIV_BY_ACCEL;
          div_req.dividend = DIV_W'(mul_rsp.product);
          state_nxt        = ST_QUAD;
        end
      end

      ST_QUAD: begin
        if (div_rsp.done) begin
          delta_nxt = delta_r + DELTA_W'(div_rsp.quotient);
          state_nxt = ST_APPLY;
        end
      end

      ST_APPLY: begin
        // Clamp to the range and drop the hold at either bound
        if (dir_r == DIR_UP) begin
          if (sum_up > (DELTA_W+1)'(max_value_r)) begin
            held_nxt = max_value_r;
            dir_nxt  = DIR_NONE;
          end else begin
            held_nxt = sum_up[VALUE_W-1:0];
          end
        end else begin
          if (delta_r > DELTA_W'(start_value_r)) begin
            held_nxt = '0;
            dir_nxt  = DIR_NONE;
          end else if (diff_dn > max_value_r) begin
            held_nxt = max_value_r;
            dir_nxt  = DIR_NONE;
          end else begin
            held_nxt = diff_dn;
          end
        end
        changed_nxt = 1'b1;
        redraw_nxt  = 1'b1;
        state_nxt   = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = held_r;
          out_en_nxt      = en_r;
          out_changed_nxt = changed_r;
          out_redraw_nxt  = redraw_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      max_value_r       <= VALUE_W'(1000);
      disable_allowed_r <= 1'b0;
      held_r            <= '0;
      en_r              <= 1'b1;
      dir_r             <= DIR_NONE;
      start_value_r     <= '0;
      start_time_r      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      max_value_r       <= max_value_nxt;
      disable_allowed_r <= disable_allowed_nxt;
      held_r            <= held_nxt;
      en_r              <= en_nxt;
      dir_r             <= dir_nxt;
      start_value_r     <= start_value_nxt;
      start_time_r      <= start_time_nxt;
      out_valid_r       <= out_valid_nxt;
    end
    action_r      <= action_nxt;
    button_r      <= button_nxt;
    press_r       <= press_nxt;
    now_r         <= now_nxt;
    t_r           <= t_nxt;
    scale_r       <= scale_nxt;
    delta_r       <= delta_nxt;
    changed_r     <= changed_nxt;
    redraw_r      <= redraw_nxt;
    out_value_r   <= out_value_nxt;
    out_en_r      <= out_en_nxt;
    out_changed_r <= out_changed_nxt;
    out_redraw_r  <= out_redraw_nxt;
  end

  // A tick update never leaves the value above the limit
  a_apply_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY && !cfg_we |=> held_r <= max_value_r)
    else $error("value above limit after tick update");

  // A value change always comes with a redraw
  a_change_redraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_changed_r || out_redraw_r)
    else $error("value change without redraw");

  // A blocked result keeps the sequencer in its final state
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && !out_if.ready |=> state_r == ST_FIN)
    else $error("sequencer left final state while output blocked");

  // Divider results arrive only while the sequencer waits for one
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_LIN || state_r == ST_SCALE || state_r == ST_QUAD)
    else $error("divider result outside a waiting state");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import aarv_pkg::*;

  // Cycles with no handshake on either channel before the run is called dead.
  // The limit lies well above the slowest request (quadratic tick) and the long
  // receiver hold-off, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT = 5000;
  // Cycles to watch for stray results once nothing is expected any more
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  // One request on the input channel, and one setting on the result channel
  typedef struct packed {
    logic              action;
    logic [1:0]        button_id;
    logic              is_press;
    logic [TIME_W-1:0] now_ms;
  } button_request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] current_value;
    logic               is_enabled;
    logic               value_changed;
    logic               needs_redraw;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [VALUE_W-1:0] cfg_wdata;

  aarv_in_if  in_if();
  aarv_out_if out_if();

  accelerated_auto_repeat_value_setter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: register copies and the value setter's own state,
  // starting from their reset values
  logic [VALUE_W-1:0] lim_max        = 16'd1000;
  logic               lim_disable_ok = 1'b0;
  logic [VALUE_W-1:0] cur_value      = '0;
  logic               cur_enabled    = 1'b1;
  hold_dir_t          hold_dir       = DIR_NONE;
  logic [VALUE_W-1:0] hold_from_value = '0;
  logic [TIME_W-1:0]  hold_from_ms   = '0;

  // Settings still owed by the block, oldest first
  setting_t expected_settings[$];

  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_off_len  = 0;
  int unsigned quiet_cycles  = 0;

  // Work out the setting that one request leaves behind, and advance the
  // predictor state. Sums are taken 64 bits wide so nothing wraps before
  // the clamp.
  function automatic setting_t predict_setting(input button_request_t req);
    setting_t                 s;
    logic [TIME_W-1:0]        elapsed;
    logic [TIME_W-1:0]        t;
    logic [TIME_W-1:0]        t2;
    logic [63:0]              scale;
    logic [63:0]              delta;
    logic signed [63:0]       moved_value;
    s.value_changed = 1'b0;
    s.needs_redraw  = 1'b0;
    if (req.action == ACT_TICK) begin
      elapsed = req.now_ms - hold_from_ms;
      if (hold_dir != DIR_NONE && elapsed > DELAY_MS) begin
        t     = elapsed - DELAY_MS;
        delta = 64'(t / STEP_MS);
        if (t > ACCEL_MS) begin
          t2    = (t - ACCEL_MS) >> 2;
          scale = 64'(lim_max / 16'd100);
          if (scale != 0) begin
            if (t2 > 32'(T2_CAP))
              t2 = 32'(T2_CAP);
            delta = delta + (64'(t2) * 64'(t2) * scale) / 64'(ACCEL_DIV);
          end
        end
        if (hold_dir == DIR_UP)
          moved_value = $signed({48'd0, hold_from_value} + delta);
        else
          moved_value = $signed({48'd0, hold_from_value} - delta);
        // Clamp both ways: a start value above a lowered limit comes down too
        if (moved_value > $signed({48'd0, lim_max})) begin
          moved_value = $signed({48'd0, lim_max});
          hold_dir    = DIR_NONE;
        end else if (moved_value < 64'sd0) begin
          moved_value = 64'sd0;
          hold_dir    = DIR_NONE;
        end
        cur_value       = moved_value[VALUE_W-1:0];
        s.value_changed = 1'b1;
        s.needs_redraw  = 1'b1;
      end
    end else if (req.button_id != BTN_IGNORE) begin
      if (req.is_press) begin
        if (!cur_enabled) begin
          cur_enabled    = 1'b1;
          s.needs_redraw = 1'b1;
        end else if (req.button_id == BTN_TOGGLE && lim_disable_ok) begin
          cur_enabled    = 1'b0;
          s.needs_redraw = 1'b1;
        end else if (hold_dir != DIR_NONE) begin
          hold_dir = DIR_NONE;
        end else if ((req.button_id == BTN_UP && cur_value < lim_max) ||
                     (req.button_id == BTN_DOWN && cur_value != 0)) begin
          if (req.button_id == BTN_UP) begin
            hold_dir  = DIR_UP;
            cur_value = cur_value + 1'b1;
          end else begin
            hold_dir  = DIR_DOWN;
            cur_value = cur_value - 1'b1;
          end
          hold_from_value = cur_value;
          hold_from_ms    = req.now_ms;
          s.value_changed = 1'b1;
          s.needs_redraw  = 1'b1;
        end
      end else if (req.button_id == BTN_UP || req.button_id == BTN_DOWN) begin
        hold_dir = DIR_NONE;
      end
    end
    s.current_value = cur_value;
    s.is_enabled    = cur_enabled;
    return s;
  endfunction

  // Offer one request and hold it until the block takes it. The sender runs
  // in bursts: at the end of a burst drop valid for a random gap. Valid is
  // left high on return so back-to-back requests need no second assignment.
  task automatic send_request(input logic action, input logic [1:0] button,
                              input logic press, input logic [TIME_W-1:0] now);
    button_request_t req;
    req.action    = action;
    req.button_id = button;
    req.is_press  = press;
    req.now_ms    = now;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= action;
    in_if.button_id <= button;
    in_if.is_press  <= press;
    in_if.now_ms    <= now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_settings.push_back(predict_setting(req));
    requests_sent++;
    burst_left--;
  endtask

  // Registers change only while the block is idle: drop valid, wait for every
  // owed setting, then write both registers on consecutive edges.
  task automatic apply_limits(input logic [VALUE_W-1:0] max_v, input logic dis_ok);
    in_if.valid <= 1'b0;
    while (expected_settings.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_VALUE;
    cfg_wdata <= max_v;
    @(posedge clk);
    cfg_index <= CFG_DISABLE_ALLOWED;
    cfg_wdata <= VALUE_W'(dis_ok);
    @(posedge clk);
    cfg_we         <= 1'b0;
    lim_max        = max_v;
    lim_disable_ok = dis_ok;
  endtask

  // Out of reset: nothing held, so a tick, a down at zero, the ignored button
  // and a toggle that may not disable all leave the value alone.
  task automatic test_power_on_state();
    send_request(ACT_TICK, BTN_DOWN, 1'b0, 32'd100);
    send_request(ACT_BUTTON, BTN_DOWN, 1'b1, 32'd200);
    send_request(ACT_BUTTON, BTN_IGNORE, 1'b1, 32'd300);
    send_request(ACT_BUTTON, BTN_TOGGLE, 1'b1, 32'd400);
    send_request(ACT_BUTTON, BTN_TOGGLE, 1'b0, 32'd450);
  endtask

  // Single step, the 500 ms threshold on both sides, the linear ramp,
  // release, and a second press that cancels the hold.
  task automatic test_step_and_ramp();
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd1000);
    send_request(ACT_TICK, BTN_IGNORE, 1'b1, 32'd1500);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd1501);
    send_request(ACT_TICK, BTN_UP, 1'b0, 32'd1600);
    send_request(ACT_BUTTON, BTN_UP, 1'b0, 32'd1700);
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd5000);
    send_request(ACT_BUTTON, BTN_DOWN, 1'b1, 32'd5001);
  endtask

  // Quadratic term, clamp at the top, a time stamp that wraps, and an elapsed
  // time so large that the quadratic input saturates and the value hits zero.
  task automatic test_acceleration_and_clamp();
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd10000);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd12900);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd52500);
    send_request(ACT_BUTTON, BTN_DOWN, 1'b1, 32'hFFFF_FF00);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'h0000_0100);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'hFFFF_FEFF);
  endtask

  // With disabling allowed: the toggle disables, a running hold keeps going
  // while disabled, the ignored button stays ignored, any press re-enables.
  task automatic test_toggle_disable();
    apply_limits(16'd1000, 1'b1);
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd100);
    send_request(ACT_BUTTON, BTN_TOGGLE, 1'b1, 32'd200);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd800);
    send_request(ACT_BUTTON, BTN_IGNORE, 1'b1, 32'd850);
    send_request(ACT_BUTTON, BTN_DOWN, 1'b1, 32'd900);
  endtask

  // Limit lowered to zero under a non-zero value: up cannot start, down
  // starts, and the next tick pulls the value down to the limit.
  task automatic test_limits_moved();
    send_request(ACT_BUTTON, BTN_UP, 1'b0, 32'd950);
    apply_limits(16'd0, 1'b0);
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd1000);
    send_request(ACT_BUTTON, BTN_DOWN, 1'b1, 32'd1100);
    send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd1700);
  endtask

  // Hold the result channel off for a long stretch while requests keep
  // coming, so the block fills and stalls its input.
  task automatic test_output_backpressure();
    apply_limits(16'd500, 1'b0);
    hold_off_len = HOLD_OFF_CYCLES;
    send_request(ACT_BUTTON, BTN_UP, 1'b1, 32'd7000);
    for (int k = 1; k <= 8; k++)
      send_request(ACT_TICK, BTN_IGNORE, 1'b0, 32'd7000 + 32'(k) * 32'd700);
    send_request(ACT_BUTTON, BTN_UP, 1'b0, 32'd14000);
  endtask

  // Mostly well-formed holds: a press at a random time stamp, a run of ticks
  // at growing elapsed times with the odd stray press, then usually a
  // release. The rest is noise with every field random.
  task automatic test_random_sessions(input int unsigned n_requests);
    int unsigned        first;
    int unsigned        n_ticks;
    logic [1:0]         btn;
    logic [TIME_W-1:0]  clock_ms;
    first = requests_sent;
    while (requests_sent - first < n_requests) begin
      if ($urandom_range(0, 9) < 7) begin
        btn      = ($urandom_range(0, 1) != 0) ? BTN_UP : BTN_DOWN;
        clock_ms = $urandom();
        send_request(ACT_BUTTON, btn, 1'b1, clock_ms);
        n_ticks = $urandom_range(1, 10);
        for (int k = 0; k < n_ticks; k++) begin
          // advance: hover round the threshold, ramp, accelerate, or jump
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: clock_ms += $urandom_range(0, 200);
            7, 8, 9, 10, 11, 12, 13: clock_ms += $urandom_range(100, 1500);
            14, 15, 16, 17: clock_ms += $urandom_range(1000, 60000);
            default: clock_ms += $urandom();
          endcase
          case ($urandom_range(0, 19))
            0: send_request(ACT_BUTTON, 2'($urandom), 1'b1, clock_ms);
            1: send_request(ACT_BUTTON, BTN_TOGGLE, 1'($urandom), clock_ms);
            default: send_request(ACT_TICK, 2'($urandom), 1'($urandom), clock_ms);
          endcase
        end
        if ($urandom_range(0, 4) != 0)
          send_request(ACT_BUTTON, btn, 1'b0, clock_ms + $urandom_range(0, 50));
      end else begin
        send_request(1'($urandom), 2'($urandom), 1'($urandom), $urandom());
      end
    end
  endtask

  // Result channel receiver: stalls on a pattern of its own that switches to a
  // random mode at random intervals, plus the long hold-off when asked for one.
  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic [7:0]  pattern;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    pattern   = 8'hA5;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        hold_left    = hold_off_len;
        hold_off_len = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
        pattern   = 8'($urandom);
      end
      mode_left--;
      pattern = {pattern[6:0], pattern[7]};
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom);
          2: out_if.ready <= pattern[0];
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare every accepted setting with the oldest one owed
  always @(posedge clk) begin : result_check
    setting_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_settings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected setting value=%0d enabled=%0b changed=%0b redraw=%0b",
                   $realtime, out_if.current_value, out_if.is_enabled,
                   out_if.value_changed, out_if.needs_redraw);
      end else begin
        want = expected_settings.pop_front();
        if (out_if.current_value !== want.current_value ||
            out_if.is_enabled !== want.is_enabled ||
            out_if.value_changed !== want.value_changed ||
            out_if.needs_redraw !== want.needs_redraw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: setting exp value=%0d en=%0b chg=%0b rdw=%0b, got %0d %0b %0b %0b",
                     $realtime, want.current_value, want.is_enabled, want.value_changed,
                     want.needs_redraw, out_if.current_value, out_if.is_enabled,
                     out_if.value_changed, out_if.needs_redraw);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MAX_VALUE;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_BUTTON;
    in_if.button_id <= BTN_IGNORE;
    in_if.is_press  <= 1'b0;
    in_if.now_ms    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_state();
    test_step_and_ramp();
    test_acceleration_and_clamp();
    test_toggle_disable();
    test_limits_moved();
    test_output_backpressure();

    // Random phases across the register extremes and a few random settings
    apply_limits(16'd1000, 1'b0);
    test_random_sessions(250);
    apply_limits(16'hFFFF, 1'b1);
    test_random_sessions(350);
    apply_limits(16'd0, 1'b0);
    test_random_sessions(100);
    apply_limits(16'd99, 1'b1);
    test_random_sessions(200);
    repeat (6) begin
      apply_limits(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom),
                   1'($urandom));
      test_random_sessions(100);
    end

    // Drain, then watch a while longer for stray results
    in_if.valid <= 1'b0;
    while (expected_settings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += expected_settings.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
